// ===== hdl/vertex_rotate_project_3d_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform core
// Expects clk and rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_3D_CORE_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_3D_CORE_MACROS_SVH

// same-cycle implication
`define VRP3D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vrp3d assertion failed");

// next-cycle implication
`define VRP3D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrp3d assertion failed");

`endif

// ===== hdl/vrp3d_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp3d_pkg
// Shared constants of the vertex rotate/project core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vrp3d_pkg;

  localparam int ANGLE_FIELD_BITS = 12;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int REG_ADDR_BITS = 3;

  typedef enum logic [REG_ADDR_BITS-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_CENTER_Z     = 3'd2,
    REG_ZOOM         = 3'd3,
    REG_HEIGHT_SCALE = 3'd4,
    REG_ANGLES       = 3'd5,
    REG_PAN_X        = 3'd6,
    REG_PAN_Y        = 3'd7
  } reg_idx_t;

endpackage
`default_nettype wire

// ===== hdl/vertex_rotate_project_3d_core.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_3d_core
// Rotates a 3D map vertex by three Euler angles and projects it to screen x,y.
//
//   channel   handshake                         payload
//   input     start, busy (transfer: start&!busy) in_point_x/y/z, in_color_in
//   result    out_valid (one-cycle strobe)        out_screen_x/y, out_color_out
//   config    APB psel/penable/pwrite, pready=1   paddr, pwdata, prdata
//
// One vertex per cycle while busy is low; results leave the vrp3d_xform pipeline in order.
// After reset and after each rotation_angles write, busy stays high
// while the coefficient sequencer runs its ROM lookups and 12 shared multiplies.
// Reset is synchronous, active low; the result side cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_rotate_project_3d_core_macros.svh"
module vertex_rotate_project_3d_core
  import vrp3d_pkg::*;
#(
  parameter int ANGLE_BITS       = 12,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COEF_FRAC_BITS   = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_point_x,
  input  wire logic signed [15:0] in_point_y,
  input  wire logic signed [15:0] in_point_z,
  input  wire logic [23:0]        in_color_in,
  output logic                    out_valid,
  output logic signed [31:0]      out_screen_x,
  output logic signed [31:0]      out_screen_y,
  output logic [23:0]             out_color_out,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);

  logic signed [23:0] center_x_r, center_y_r, center_z_r, pan_x_r, pan_y_r;
  logic [15:0]        zoom_r;
  logic signed [15:0] height_scale_r;
  logic [3*ANGLE_FIELD_BITS-1:0] angles_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     ang_wr;
  logic     coef_busy;
  logic     in_xfer;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);
  assign ang_wr  = cfg_wr && (cfg_idx == REG_ANGLES);
  assign busy    = coef_busy;
  assign in_xfer = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      center_z_r     <= '0;
      zoom_r         <= 16'd256;
      height_scale_r <= 16'sd256;
      angles_r       <= '0;
      pan_x_r        <= '0;
      pan_y_r        <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CENTER_X:     center_x_r     <= pwdata[23:0];
        REG_CENTER_Y:     center_y_r     <= pwdata[23:0];
        REG_CENTER_Z:     center_z_r     <= pwdata[23:0];
        REG_ZOOM:         zoom_r         <= pwdata[15:0];
        REG_HEIGHT_SCALE: height_scale_r <= pwdata[15:0];
        REG_ANGLES:       angles_r       <= pwdata[3*ANGLE_FIELD_BITS-1:0];
        REG_PAN_X:        pan_x_r        <= pwdata[23:0];
        REG_PAN_Y:        pan_y_r        <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_X:     prdata = 64'(unsigned'(center_x_r));
      REG_CENTER_Y:     prdata = 64'(unsigned'(center_y_r));
      REG_CENTER_Z:     prdata = 64'(unsigned'(center_z_r));
      REG_ZOOM:         prdata = 64'(zoom_r);
      REG_HEIGHT_SCALE: prdata = 64'(unsigned'(height_scale_r));
      REG_ANGLES:       prdata = 64'(angles_r);
      REG_PAN_X:        prdata = 64'(unsigned'(pan_x_r));
      REG_PAN_Y:        prdata = 64'(unsigned'(pan_y_r));
      default:          prdata = '0;
    endcase
  end

  logic signed [COEF_FRAC_BITS+2:0] r00, r01, r02, r10, r11, r12;

  vrp3d_coef #(
    .ANGLE_BITS       (ANGLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .COEF_FRAC_BITS   (COEF_FRAC_BITS)
  ) u_coef (
    .clk    (clk),
    .rst_n  (rst_n),
    .kick   (ang_wr),
    .angles (angles_r),
    .busy   (coef_busy),
    .r00    (r00),
    .r01    (r01),
    .r02    (r02),
    .r10    (r10),
    .r11    (r11),
    .r12    (r12)
  );

  vrp3d_xform #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_xform (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_xfer),
    .point_x      (in_point_x),
    .point_y      (in_point_y),
    .point_z      (in_point_z),
    .color_in     (in_color_in),
    .center_x     (center_x_r),
    .center_y     (center_y_r),
    .center_z     (center_z_r),
    .zoom         (zoom_r),
    .height_scale (height_scale_r),
    .pan_x        (pan_x_r),
    .pan_y        (pan_y_r),
    .r00          (r00),
    .r01          (r01),
    .r02          (r02),
    .r10          (r10),
    .r11          (r11),
    .r12          (r12),
    .out_valid    (out_valid),
    .screen_x     (out_screen_x),
    .screen_y     (out_screen_y),
    .color_out    (out_color_out)
  );

  `VRP3D_ASSERT_IMP(a_latency, in_xfer, ##6 out_valid)
  `VRP3D_ASSERT_IMP(a_no_phantom, out_valid, $past(in_xfer, 6))
  `VRP3D_ASSERT_NXT(a_ang_busy, ang_wr, busy)

endmodule
`default_nettype wire

// ===== hdl/vrp3d_coef.sv =====
// ----------------------------------------------------------------------------
// vrp3d_coef
// Sequencer that looks up sin/cos of three angles in a quarter-wave ROM and
// builds the first two rows of Rz*Ry*Rx with one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrp3d_coef
  import vrp3d_pkg::*;
#(
  parameter int ANGLE_BITS       = 12,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int COEF_FRAC_BITS   = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          kick,
  input  wire logic [3*ANGLE_FIELD_BITS-1:0] angles,
  output logic                               busy,
  output logic signed [COEF_FRAC_BITS+2:0]   r00,
  output logic signed [COEF_FRAC_BITS+2:0]   r01,
  output logic signed [COEF_FRAC_BITS+2:0]   r02,
  output logic signed [COEF_FRAC_BITS+2:0]   r10,
  output logic signed [COEF_FRAC_BITS+2:0]   r11,
  output logic signed [COEF_FRAC_BITS+2:0]   r12
);

  localparam int CW = COEF_FRAC_BITS + 3;
  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int F  = COEF_FRAC_BITS;
  localparam int LAST_STEP = 19;

  typedef logic [F:0] tab_t [0:SINE_TABLE_DEPTH];

  function automatic tab_t build_tab();
    tab_t tb;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] e;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      t = (HALF_PI_Q30 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      t2 = (t * t) >> 30;
      term = t;
      sum = $signed(t);
      for (int k = 1; k <= 10; k++) begin
        term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      e = (sum + (64'sd1 <<< (29 - F))) >>> (30 - F);
      if (e < 0) e = 0;
      if (e > (64'sd1 <<< F)) e = 64'sd1 <<< F;
      tb[i] = e[F:0];
    end
    return tb;
  endfunction

  localparam tab_t SIN_TAB = build_tab();

  logic [4:0] step_r;
  logic       run_r;

  // ROM address generation
  logic [2:0]                   vsel;
  logic [ANGLE_FIELD_BITS-1:0]  fa;
  logic [ANGLE_FIELD_BITS+15:0] fa_ext;
  logic [ANGLE_BITS-1:0]        ang;
  logic [ANGLE_BITS-1:0]        ang_q;
  logic [ANGLE_BITS-3:0]        rem;
  logic [ANGLE_BITS-3+IW:0]     scaled;
  logic [IW-1:0]                idx_raw;
  logic [IW-1:0]                idx;

  always_comb begin
    vsel   = step_r[2:0];
    fa     = angles[ANGLE_FIELD_BITS*vsel[2:1] +: ANGLE_FIELD_BITS];
    fa_ext = {fa, 16'h0000};
    ang    = fa_ext[ANGLE_FIELD_BITS+15 -: ANGLE_BITS];
    ang_q  = vsel[0] ? ang + (ANGLE_BITS'(1) << (ANGLE_BITS - 2)) : ang;
    rem    = ang_q[ANGLE_BITS-3:0];
    scaled = (ANGLE_BITS-2+IW)'(rem) * (ANGLE_BITS-2+IW)'(SINE_TABLE_DEPTH);
    idx_raw = scaled[ANGLE_BITS-2 +: IW];
    idx    = ang_q[ANGLE_BITS-2] ? IW'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;
  end

  logic [F:0] rom_q_r;
  logic       neg_r;
  logic signed [CW-1:0] sv;

  always_ff @(posedge clk) begin
    rom_q_r <= SIN_TAB[idx];
    neg_r   <= ang_q[ANGLE_BITS-1];
  end

  assign sv = neg_r ? -$signed(CW'(rom_q_r)) : $signed(CW'(rom_q_r));

  logic signed [CW-1:0] sx_r, cx_r, sy_r, cy_r, sz_r, cz_r;
  logic signed [CW-1:0] t0_r, t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r, t8_r, t9_r;
  logic signed [CW-1:0] t10_r, t11_r;
  logic signed [CW-1:0] op_a, op_b;
  logic signed [2*CW-1:0] prod;
  logic signed [2*CW-1:0] prod_rnd;
  logic signed [CW-1:0] m_res;

  always_comb begin
    unique case (step_r)
      5'd7:    begin op_a = cy_r; op_b = cz_r; end
      5'd8:    begin op_a = cz_r; op_b = sx_r; end
      5'd9:    begin op_a = t1_r; op_b = sy_r; end
      5'd10:   begin op_a = cx_r; op_b = sz_r; end
      5'd11:   begin op_a = cx_r; op_b = cz_r; end
      5'd12:   begin op_a = t4_r; op_b = sy_r; end
      5'd13:   begin op_a = sx_r; op_b = sz_r; end
      5'd14:   begin op_a = cy_r; op_b = sz_r; end
      5'd15:   begin op_a = sx_r; op_b = sy_r; end
      5'd16:   begin op_a = t7_r; op_b = sz_r; end
      5'd17:   begin op_a = cx_r; op_b = sy_r; end
      5'd18:   begin op_a = t9_r; op_b = sz_r; end
      default: begin op_a = '0;   op_b = '0;   end
    endcase
    prod     = (2*CW)'(op_a) * (2*CW)'(op_b);
    prod_rnd = (prod + ((2*CW)'(1) <<< (F - 1))) >>> F;
    m_res    = prod_rnd[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b1;
      step_r <= '0;
    end else if (kick) begin
      run_r  <= 1'b1;
      step_r <= '0;
    end else if (run_r) begin
      if (step_r == 5'(LAST_STEP)) begin
        run_r <= 1'b0;
      end
      step_r <= step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (run_r) begin
      unique case (step_r)
        5'd1:  sx_r  <= sv;
        5'd2:  cx_r  <= sv;
        5'd3:  sy_r  <= sv;
        5'd4:  cy_r  <= sv;
        5'd5:  sz_r  <= sv;
        5'd6:  cz_r  <= sv;
        5'd7:  t0_r  <= m_res;
        5'd8:  t1_r  <= m_res;
        5'd9:  t2_r  <= m_res;
        5'd10: t3_r  <= m_res;
        5'd11: t4_r  <= m_res;
        5'd12: t5_r  <= m_res;
        5'd13: t6_r  <= m_res;
        5'd14: t11_r <= m_res;
        5'd15: t7_r  <= m_res;
        5'd16: t8_r  <= m_res;
        5'd17: t9_r  <= m_res;
        5'd18: t10_r <= m_res;
        5'd19: begin
          r00 <= t0_r;
          r01 <= t2_r - t3_r;
          r02 <= t5_r + t6_r;
          r10 <= t11_r;
          r11 <= t4_r + t8_r;
          r12 <= t10_r - t1_r;
        end
        default: ;
      endcase
    end
  end

  assign busy = run_r;

endmodule
`default_nettype wire

// ===== hdl/vrp3d_xform.sv =====
// ----------------------------------------------------------------------------
// vrp3d_xform
// Six-stage vertex pipeline: center offset, zoom, height scale, rotation
// products, rounding, pan and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrp3d_xform
  import vrp3d_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic signed [15:0]          point_x,
  input  wire logic signed [15:0]          point_y,
  input  wire logic signed [15:0]          point_z,
  input  wire logic [23:0]                 color_in,
  input  wire logic signed [23:0]          center_x,
  input  wire logic signed [23:0]          center_y,
  input  wire logic signed [23:0]          center_z,
  input  wire logic [15:0]                 zoom,
  input  wire logic signed [15:0]          height_scale,
  input  wire logic signed [23:0]          pan_x,
  input  wire logic signed [23:0]          pan_y,
  input  wire logic signed [COEF_FRAC_BITS+2:0] r00,
  input  wire logic signed [COEF_FRAC_BITS+2:0] r01,
  input  wire logic signed [COEF_FRAC_BITS+2:0] r02,
  input  wire logic signed [COEF_FRAC_BITS+2:0] r10,
  input  wire logic signed [COEF_FRAC_BITS+2:0] r11,
  input  wire logic signed [COEF_FRAC_BITS+2:0] r12,
  output logic                             out_valid,
  output logic signed [31:0]               screen_x,
  output logic signed [31:0]               screen_y,
  output logic [23:0]                      color_out
);

  localparam int CW = COEF_FRAC_BITS + 3;
  localparam int F  = COEF_FRAC_BITS;
  localparam int PW = 42 + CW;
  localparam int SW = PW + 2;
  localparam int OW = SW + 1;

  logic [5:1] v_r;
  logic [23:0] col1_r, col2_r, col3_r, col4_r, col5_r;

  // stage 1: offset
  logic signed [24:0] dx_r, dy_r, dz_r;
  always_ff @(posedge clk) begin
    dx_r   <= 25'($signed({point_x, 8'h00})) - 25'(center_x);
    dy_r   <= 25'($signed({point_y, 8'h00})) - 25'(center_y);
    dz_r   <= 25'($signed({point_z, 8'h00})) - 25'(center_z);
    col1_r <= color_in;
  end

  // stage 2: zoom and height factor
  logic signed [16:0] zm;
  logic signed [41:0] xp, yp, xr, yr;
  logic signed [40:0] hp, hr;
  logic signed [33:0] x2_r, y2_r;
  logic signed [32:0] h2_r;
  always_comb begin
    zm = $signed({1'b0, zoom});
    xp = 42'(dx_r) * 42'(zm);
    yp = 42'(dy_r) * 42'(zm);
    hp = 41'(dz_r) * 41'(height_scale);
    xr = (xp + 42'sd128) >>> 8;
    yr = (yp + 42'sd128) >>> 8;
    hr = (hp + 41'sd128) >>> 8;
  end
  always_ff @(posedge clk) begin
    x2_r   <= xr[33:0];
    y2_r   <= yr[33:0];
    h2_r   <= hr[32:0];
    col2_r <= col1_r;
  end

  // stage 3: zoom on height
  logic signed [49:0] zp, zr;
  logic signed [33:0] x3_r, y3_r;
  logic signed [41:0] z3_r;
  always_comb begin
    zp = 50'(h2_r) * 50'(zm);
    zr = (zp + 50'sd128) >>> 8;
  end
  always_ff @(posedge clk) begin
    x3_r   <= x2_r;
    y3_r   <= y2_r;
    z3_r   <= zr[41:0];
    col3_r <= col2_r;
  end

  // stage 4: rotation products
  logic signed [PW-1:0] p00_r, p01_r, p02_r, p10_r, p11_r, p12_r;
  always_ff @(posedge clk) begin
    p00_r  <= PW'(x3_r) * PW'(r00);
    p01_r  <= PW'(y3_r) * PW'(r01);
    p02_r  <= PW'(z3_r) * PW'(r02);
    p10_r  <= PW'(x3_r) * PW'(r10);
    p11_r  <= PW'(y3_r) * PW'(r11);
    p12_r  <= PW'(z3_r) * PW'(r12);
    col4_r <= col3_r;
  end

  // stage 5: sum and round
  logic signed [SW-1:0] sx5, sy5;
  logic signed [SW-1:0] sx5_r, sy5_r;
  always_comb begin
    sx5 = SW'(p00_r) + SW'(p01_r) + SW'(p02_r) + (SW'(1) <<< (F - 1));
    sy5 = SW'(p10_r) + SW'(p11_r) + SW'(p12_r) + (SW'(1) <<< (F - 1));
  end
  always_ff @(posedge clk) begin
    sx5_r  <= sx5 >>> F;
    sy5_r  <= sy5 >>> F;
    col5_r <= col4_r;
  end

  // stage 6: center, pan, saturate
  localparam logic signed [OW-1:0] MAX32 = OW'(64'sh7FFF_FFFF);
  localparam logic signed [OW-1:0] MIN32 = -OW'(64'sh7FFF_FFFF) - OW'(1);
  logic signed [OW-1:0] ox, oy;
  logic signed [31:0]   ox_sat, oy_sat;
  always_comb begin
    ox = OW'(sx5_r) + OW'(center_x) + OW'(pan_x);
    oy = OW'(sy5_r) + OW'(center_y) + OW'(pan_y);
    if (ox > MAX32)      ox_sat = 32'sh7FFF_FFFF;
    else if (ox < MIN32) ox_sat = -32'sh7FFF_FFFF - 32'sd1;
    else                 ox_sat = ox[31:0];
    if (oy > MAX32)      oy_sat = 32'sh7FFF_FFFF;
    else if (oy < MIN32) oy_sat = -32'sh7FFF_FFFF - 32'sd1;
    else                 oy_sat = oy[31:0];
  end
  always_ff @(posedge clk) begin
    screen_x  <= ox_sat;
    screen_y  <= oy_sat;
    color_out <= col5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_valid <= 1'b0;
    end else begin
      v_r       <= {v_r[4:1], in_valid};
      out_valid <= v_r[5];
    end
  end

endmodule
`default_nettype wire
